### sv/lrcv_pkg.sv
// ----------------------------------------------------------------------------
// lrcv_pkg
// Shared widths, register indexes and types of the lidar range clip and
// voxel downsample unit.
// ----------------------------------------------------------------------------
package lrcv_pkg;

  localparam int COORD_W    = 24;
  localparam int TIME_W     = 32;
  localparam int RANGE_W    = 23;
  localparam int VOXEL_W    = 16;
  localparam int SQ_W       = 48;
  localparam int HASH_W     = 32;
  localparam int DVS_W      = 17;
  localparam int EPOCH_W    = 8;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int PROBE_LIMIT_DEF = 8;

  localparam logic [HASH_W-1:0] HASH_GOLDEN = 32'h9e3779b9;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 23'd100000;

  // Register indexes (word address)
  localparam logic [1:0] REG_MIN_RANGE  = 2'd0;
  localparam logic [1:0] REG_MAX_RANGE  = 2'd1;
  localparam logic [1:0] REG_VOXEL_SIZE = 2'd2;

  typedef struct packed {
    logic [RANGE_W-1:0] min_range;
    logic [RANGE_W-1:0] max_range;
    logic [VOXEL_W-1:0] voxel_size;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] kx;
    logic [COORD_W-1:0] ky;
    logic [COORD_W-1:0] kz;
  } key_t;

endpackage

### sv/lrcv_if.sv
// ----------------------------------------------------------------------------
// lrcv_in_if / lrcv_out_if
// Valid/ready channels carrying lidar points in and kept points out.
// ----------------------------------------------------------------------------
interface lrcv_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lrcv_pkg::COORD_W-1:0]  point_x;
  logic signed [lrcv_pkg::COORD_W-1:0]  point_y;
  logic signed [lrcv_pkg::COORD_W-1:0]  point_z;
  logic        [lrcv_pkg::TIME_W-1:0]   time_tag;
  logic                                 last_in_scan;

  modport source (output valid, point_x, point_y, point_z, time_tag, last_in_scan,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, time_tag, last_in_scan,
                  output ready);
endinterface

interface lrcv_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lrcv_pkg::COORD_W-1:0]  out_x;
  logic signed [lrcv_pkg::COORD_W-1:0]  out_y;
  logic signed [lrcv_pkg::COORD_W-1:0]  out_z;
  logic        [lrcv_pkg::TIME_W-1:0]   out_time;
  logic                                 point_valid;
  logic                                 table_overflow;
  logic                                 scan_end;

  modport source (output valid, out_x, out_y, out_z, out_time, point_valid,
                  table_overflow, scan_end, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_time, point_valid,
                  table_overflow, scan_end, output ready);
endinterface

### sv/lrcv_cfg_regs.sv
// ----------------------------------------------------------------------------
// lrcv_cfg_regs
// APB-style register file: minimum range, maximum range, voxel size.
// ----------------------------------------------------------------------------
module lrcv_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrcv_pkg::CFG_AW-1:0]   paddr,
  input  logic [lrcv_pkg::CFG_DW-1:0]   pwdata,
  output logic [lrcv_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output lrcv_pkg::cfg_t                cfg
);

  lrcv_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // Write the addressed register, mask to its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range  <= '0;
      cfg_r.max_range  <= lrcv_pkg::MAX_RANGE_RST;
      cfg_r.voxel_size <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        lrcv_pkg::REG_MIN_RANGE:  cfg_r.min_range  <= pwdata[lrcv_pkg::RANGE_W-1:0];
        lrcv_pkg::REG_MAX_RANGE:  cfg_r.max_range  <= pwdata[lrcv_pkg::RANGE_W-1:0];
        lrcv_pkg::REG_VOXEL_SIZE: cfg_r.voxel_size <= pwdata[lrcv_pkg::VOXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      lrcv_pkg::REG_MIN_RANGE:  prdata = lrcv_pkg::CFG_DW'(cfg_r.min_range);
      lrcv_pkg::REG_MAX_RANGE:  prdata = lrcv_pkg::CFG_DW'(cfg_r.max_range);
      lrcv_pkg::REG_VOXEL_SIZE: prdata = lrcv_pkg::CFG_DW'(cfg_r.voxel_size);
      default:                  prdata = '0;
    endcase
  end

endmodule

### sv/lrcv_div_unit.sv
// ----------------------------------------------------------------------------
// lrcv_div_unit
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// ----------------------------------------------------------------------------
module lrcv_div_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lrcv_pkg::HASH_W-1:0]   dividend,
  input  logic [lrcv_pkg::DVS_W-1:0]    divisor,
  output logic                          done,
  output logic [lrcv_pkg::HASH_W-1:0]   quot,
  output logic [lrcv_pkg::DVS_W-1:0]    rem
);

  localparam int CW = $clog2(lrcv_pkg::HASH_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CW-1:0]                 cnt_r;
  logic [lrcv_pkg::HASH_W-1:0]   quot_r;
  logic [lrcv_pkg::DVS_W-1:0]    rem_r;
  logic [lrcv_pkg::DVS_W-1:0]    dvs_r;
  logic [lrcv_pkg::DVS_W:0]      trial;
  logic [lrcv_pkg::DVS_W:0]      diff;
  logic                          fits;

  // One shift-subtract step
  assign trial = {rem_r, quot_r[lrcv_pkg::HASH_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(lrcv_pkg::HASH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[lrcv_pkg::HASH_W-2:0], fits};
      rem_r  <= fits ? diff[lrcv_pkg::DVS_W-1:0] : trial[lrcv_pkg::DVS_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

### sv/lrcv_voxel_table.sv
// ----------------------------------------------------------------------------
// lrcv_voxel_table
// Voxel key memory: one port, each word holds an epoch tag and a voxel key.
// ----------------------------------------------------------------------------
module lrcv_voxel_table #(
  parameter int TABLE_DEPTH = lrcv_pkg::TABLE_DEPTH_DEF,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 addr,
  input  logic [lrcv_pkg::EPOCH_W-1:0]  wtag,
  input  lrcv_pkg::key_t                wkey,
  output logic [lrcv_pkg::EPOCH_W-1:0]  rtag,
  output lrcv_pkg::key_t                rkey
);

  localparam int WW = lrcv_pkg::EPOCH_W + $bits(lrcv_pkg::key_t);

  logic [WW-1:0] mem [TABLE_DEPTH];
  logic [WW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= {wtag, wkey};
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rtag = rdata_r[WW-1 -: lrcv_pkg::EPOCH_W];
  assign rkey = rdata_r[$bits(lrcv_pkg::key_t)-1:0];

endmodule

### sv/lidar_range_clip_voxel_downsample_unit.sv
// ----------------------------------------------------------------------------
// lidar_range_clip_voxel_downsample_unit
// Range clip and first-point-per-voxel downsample of a lidar point stream.
// ----------------------------------------------------------------------------
// Points enter on in_pt (valid/ready) one at a time; kept points and scan-end
// results leave on out_pt (valid/ready) in arrival order. Registers sit on
// the APB-style cfg_ port; the user is to write them only while the unit is
// idle; the unit itself does not enforce this. A point first runs five
// squarings through one shared 24x24 multiplier (S_SQ) and is then
// range-checked (S_CMP). Dropped points, or any point with voxel size zero,
// finish there. Otherwise one shared restoring divider forms the three voxel
// keys, S_H1 and S_H2 form the hash, whose low bits give the home slot
// (TABLE_DEPTH is a power of two), and each probe of the key memory reads,
// then compares (S_RD, S_CHK), for one to PROBE_LIMIT probes. One point is
// in work at a time; in_pt.ready is high only while the sequencer is idle.
// A stalled receiver holds only the output register; the next point is taken
// meanwhile and waits at its end. After reset, and after every 255th scan
// end, a clearing pass writes TABLE_DEPTH words (one per cycle) of the key
// memory; no point is taken during it. Other scan ends clear by epoch change.
// ----------------------------------------------------------------------------
module lidar_range_clip_voxel_downsample_unit #(
  parameter int TABLE_DEPTH = lrcv_pkg::TABLE_DEPTH_DEF,
  parameter int PROBE_LIMIT = lrcv_pkg::PROBE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lrcv_in_if.sink                       in_pt,
  lrcv_out_if.source                    out_pt,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lrcv_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [lrcv_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [lrcv_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int CW = lrcv_pkg::COORD_W;
  localparam int EW = lrcv_pkg::EPOCH_W;
  localparam int SW = lrcv_pkg::SQ_W;
  localparam int HW = lrcv_pkg::HASH_W;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_SQ    = 11'b00000000100,
    S_CMP   = 11'b00000001000,
    S_DGO   = 11'b00000010000,
    S_DWAIT = 11'b00000100000,
    S_H1    = 11'b00001000000,
    S_H2    = 11'b00010000000,
    S_RD    = 11'b00100000000,
    S_CHK   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  lrcv_pkg::cfg_t cfg;

  state_t                state_r, state_nxt;
  logic signed [CW-1:0]  px_r, py_r, pz_r;
  logic [lrcv_pkg::TIME_W-1:0] time_r;
  logic                  last_r;
  logic [2:0]            mcnt_r, mcnt_nxt;
  logic [SW-1:0]         prod_r;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic [SW-1:0]         mn_r, mn_nxt;
  logic [SW-1:0]         mx_r, mx_nxt;
  logic                  kept_r, kept_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [1:0]            dcnt_r, dcnt_nxt;
  lrcv_pkg::key_t        key_r, key_nxt;
  logic [HW-1:0]         h_r, h_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [PW-1:0]         pcnt_r, pcnt_nxt;
  logic [EW-1:0]         epoch_r, epoch_nxt;
  logic [AW-1:0]         ccnt_r, ccnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [CW-1:0]  ox_r, oy_r, oz_r;
  logic [lrcv_pkg::TIME_W-1:0] ot_r;
  logic                  opv_r, oovf_r, oend_r;
  logic                  out_load;

  logic signed [CW-1:0]  mop;
  logic signed [SW-1:0]  mprod;
  logic                  div_start, div_done;
  logic [HW-1:0]         div_dividend, div_quot;
  logic [lrcv_pkg::DVS_W-1:0] div_divisor, div_rem;
  logic signed [CW-1:0]  coord;
  logic [CW-1:0]         coord_abs, qk, fkey;
  logic [HW-1:0]         h_mix;

  logic                  tbl_rd, tbl_wr;
  logic [AW-1:0]         tbl_addr;
  logic [EW-1:0]         tbl_wtag, tbl_rtag;
  lrcv_pkg::key_t        tbl_rkey;
  logic                  hit_valid, hit_match;

  lrcv_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lrcv_div_unit u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  lrcv_voxel_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_tbl (
    .clk   (clk),
    .rd_en (tbl_rd),
    .wr_en (tbl_wr),
    .addr  (tbl_addr),
    .wtag  (tbl_wtag),
    .wkey  (key_r),
    .rtag  (tbl_rtag),
    .rkey  (tbl_rkey)
  );

  // Shared squaring unit operand
  always_comb begin
    case (mcnt_r)
      3'd0:    mop = px_r;
      3'd1:    mop = py_r;
      3'd2:    mop = pz_r;
      3'd3:    mop = CW'(cfg.min_range);
      3'd4:    mop = CW'(cfg.max_range);
      default: mop = '0;
    endcase
  end
  assign mprod = mop * mop;

  always_ff @(posedge clk) begin
    prod_r <= mprod;
  end

  // Divider operand: coordinate magnitude over the voxel size
  always_comb begin
    case (dcnt_r)
      2'd0:    coord = px_r;
      2'd1:    coord = py_r;
      default: coord = pz_r;
    endcase
  end
  assign coord_abs    = coord[CW-1] ? (~coord + 1'b1) : coord;
  assign div_dividend = HW'(coord_abs);
  assign div_divisor  = lrcv_pkg::DVS_W'(cfg.voxel_size);
  assign div_start    = (state_r == S_DGO);

  // Floor key from magnitude quotient
  assign qk   = div_quot[CW-1:0];
  assign fkey = !coord[CW-1] ? qk : ((div_rem != '0) ? ~qk : (~qk + 1'b1));

  // Hash mixing step
  always_comb begin
    if (state_r == S_H1) begin
      h_mix = HW'(key_r.kx) ^ (HW'(key_r.ky) + lrcv_pkg::HASH_GOLDEN +
              (HW'(key_r.kx) << 6) + (HW'(key_r.kx) >> 2));
    end else begin
      h_mix = h_r ^ (HW'(key_r.kz) + lrcv_pkg::HASH_GOLDEN + (h_r << 6) + (h_r >> 2));
    end
  end

  // Probe compare
  assign hit_valid = (tbl_rtag == epoch_r);
  assign hit_match = (tbl_rkey == key_r);

  assign tbl_rd   = (state_r == S_RD);
  assign tbl_wr   = (state_r == S_CLEAR) || ((state_r == S_CHK) && !hit_valid);
  assign tbl_addr = (state_r == S_CLEAR) ? ccnt_r : slot_r;
  assign tbl_wtag = (state_r == S_CLEAR) ? '0 : epoch_r;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_pt.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    mcnt_nxt  = mcnt_r;
    sum_nxt   = sum_r;
    mn_nxt    = mn_r;
    mx_nxt    = mx_r;
    kept_nxt  = kept_r;
    ovf_nxt   = ovf_r;
    dcnt_nxt  = dcnt_r;
    key_nxt   = key_r;
    h_nxt     = h_r;
    slot_nxt  = slot_r;
    pcnt_nxt  = pcnt_r;
    epoch_nxt = epoch_r;
    ccnt_nxt  = ccnt_r;
    case (state_r)
      S_CLEAR: begin
        ccnt_nxt = ccnt_r + 1'b1;
        if (ccnt_r == AW'(TABLE_DEPTH - 1)) begin
          ccnt_nxt  = '0;
          epoch_nxt = EW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_pt.valid) begin
          mcnt_nxt  = '0;
          sum_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        // Accumulate the previous product, or store it as a range bound
        mcnt_nxt = mcnt_r + 1'b1;
        case (mcnt_r)
          3'd1, 3'd2, 3'd3: sum_nxt = sum_r + prod_r;
          3'd4:             mn_nxt  = prod_r;
          3'd5:             mx_nxt  = prod_r;
          default: ;
        endcase
        if (mcnt_r == 3'd5) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        kept_nxt = !((sum_r < mn_r) || (sum_r > mx_r));
        dcnt_nxt = '0;
        if (kept_nxt && (cfg.voxel_size != '0)) begin
          state_nxt = S_DGO;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DGO: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          dcnt_nxt = dcnt_r + 1'b1;
          case (dcnt_r)
            2'd0: begin
              key_nxt.kx = fkey;
              state_nxt  = S_DGO;
            end
            2'd1: begin
              key_nxt.ky = fkey;
              state_nxt  = S_DGO;
            end
            default: begin
              key_nxt.kz = fkey;
              state_nxt  = S_H1;
            end
          endcase
        end
      end
      S_H1: begin
        h_nxt     = h_mix;
        state_nxt = S_H2;
      end
      S_H2: begin
        // Home slot is the hash modulo the power-of-two depth
        h_nxt     = h_mix;
        slot_nxt  = h_mix[AW-1:0];
        pcnt_nxt  = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // Empty slot: insert; same key: drop; else probe on, flag overflow at the limit
        if (!hit_valid) begin
          state_nxt = S_OUT;
        end else if (hit_match) begin
          kept_nxt  = 1'b0;
          state_nxt = S_OUT;
        end else if (pcnt_r == PW'(PROBE_LIMIT - 1)) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          pcnt_nxt  = pcnt_r + 1'b1;
          slot_nxt  = (slot_r == AW'(TABLE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (out_load || (!kept_r && !last_r)) begin
          state_nxt = S_IDLE;
          if (last_r) begin
            epoch_nxt = epoch_r + 1'b1;
            if (epoch_nxt == '0) begin
              state_nxt = S_CLEAR;
            end
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_pt.ready = (state_r == S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ccnt_r      <= '0;
      epoch_r     <= '0;
      mcnt_r      <= '0;
      dcnt_r      <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ccnt_r      <= ccnt_nxt;
      epoch_r     <= epoch_nxt;
      mcnt_r      <= mcnt_nxt;
      dcnt_r      <= dcnt_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    mn_r   <= mn_nxt;
    mx_r   <= mx_nxt;
    kept_r <= kept_nxt;
    ovf_r  <= ovf_nxt;
    key_r  <= key_nxt;
    h_r    <= h_nxt;
    slot_r <= slot_nxt;
    if (in_pt.valid && in_pt.ready) begin
      px_r   <= in_pt.point_x;
      py_r   <= in_pt.point_y;
      pz_r   <= in_pt.point_z;
      time_r <= in_pt.time_tag;
      last_r <= in_pt.last_in_scan;
    end
  end

  // Output register: hold until taken; a dropped point sets valid only at scan end
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_pt.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load && (kept_r || last_r)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ox_r   <= kept_r ? px_r : '0;
      oy_r   <= kept_r ? py_r : '0;
      oz_r   <= kept_r ? pz_r : '0;
      ot_r   <= kept_r ? time_r : '0;
      opv_r  <= kept_r;
      oovf_r <= kept_r & ovf_r;
      oend_r <= last_r;
    end
  end

  assign out_pt.valid          = out_valid_r;
  assign out_pt.out_x          = ox_r;
  assign out_pt.out_y          = oy_r;
  assign out_pt.out_z          = oz_r;
  assign out_pt.out_time       = ot_r;
  assign out_pt.point_valid    = opv_r;
  assign out_pt.table_overflow = oovf_r;
  assign out_pt.scan_end       = oend_r;

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |-> (epoch_r != '0))
    else $error("epoch zero outside clearing pass");

  a_tbl_wr_when: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr |-> ((state_r == S_CLEAR) || (state_r == S_CHK)))
    else $error("table write outside clear or probe");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (pcnt_r <= PW'(PROBE_LIMIT - 1)))
    else $error("probe count beyond limit");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pt.ready) |=> (out_valid_r && $stable(ot_r)))
    else $error("pending result overwritten");

endmodule

### dv/lidar_range_clip_voxel_downsample_unit_tb.sv
// ----------------------------------------------------------------------------
// lidar_range_clip_voxel_downsample_unit_tb
// Self-checking bench for range clip and first-point-per-voxel downsample.
// A directed table covers range edges, end-of-scan results, duplicate voxels
// and a full probe window. Random scans under several register settings then
// follow. Every result is checked field by field against its expected row
// or an in-bench model of the clip, the voxel key table and the scan clear.
// ----------------------------------------------------------------------------
module lidar_range_clip_voxel_downsample_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = lrcv_pkg::COORD_W;
  localparam int TW        = lrcv_pkg::TIME_W;
  localparam int RW        = lrcv_pkg::RANGE_W;
  localparam int VW        = lrcv_pkg::VOXEL_W;
  localparam int HW        = lrcv_pkg::HASH_W;
  localparam int PAW       = lrcv_pkg::CFG_AW;
  localparam int PDW       = lrcv_pkg::CFG_DW;
  localparam int DEPTH     = lrcv_pkg::TABLE_DEPTH_DEF;
  localparam int AW        = $clog2(DEPTH);
  localparam int PROBES    = lrcv_pkg::PROBE_LIMIT_DEF;
  localparam int SETTLE    = 400;
  localparam int CYC_LIMIT = 4000000;
  localparam int N_PHASE   = 8;
  localparam int PHASE_PTS = 200;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [TW-1:0]        t;
    logic                 last;
  } point_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [TW-1:0]        t;
    logic                 kept;
    logic                 ovf;
    logic                 scan_end;
  } kept_t;

  typedef struct packed {
    point_t p;
    logic   known;
    logic   has;
    kept_t  r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [PAW-1:0] cfg_paddr = '0;
  logic [PDW-1:0] cfg_pwdata = '0;
  logic [PDW-1:0] cfg_prdata;
  logic cfg_pready;

  lrcv_in_if  pt_in ();
  lrcv_out_if pt_out ();

  lidar_range_clip_voxel_downsample_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_pt(pt_in.sink), .out_pt(pt_out.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // model state: register copy and voxel key table
  logic [RW-1:0] m_min = '0;
  logic [RW-1:0] m_max = lrcv_pkg::MAX_RANGE_RST;
  logic [VW-1:0] m_voxel = '0;
  logic [CW-1:0] seen_kx [DEPTH];
  logic [CW-1:0] seen_ky [DEPTH];
  logic [CW-1:0] seen_kz [DEPTH];
  bit            seen_occ [DEPTH];

  kept_t pending_q[$];
  int errors = 0, n_items = 0, n_results = 0, n_ovf = 0, n_ends = 0, n_kept = 0;
  int cycles = 0;
  bit in_idle_on = 1'b1, out_idle_on = 1'b1;
  int scan_left = 0;

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [CW-1:0] voxel_key(input longint a, input longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q[CW-1:0];
  endfunction

  function automatic logic [AW-1:0] home_slot(input logic [CW-1:0] kx,
                                              input logic [CW-1:0] ky,
                                              input logic [CW-1:0] kz);
    logic [HW-1:0] h;
    h = HW'(kx);
    h = h ^ (HW'(ky) + lrcv_pkg::HASH_GOLDEN + (h << 6) + (h >> 2));
    h = h ^ (HW'(kz) + lrcv_pkg::HASH_GOLDEN + (h << 6) + (h >> 2));
    return h[AW-1:0];
  endfunction

  // clip, dedup and clear; returns whether the point yields a result
  function automatic bit clip_and_dedup(input point_t p, output kept_t r);
    longint sx, sy, sz, sq, mn, mx, d;
    logic [CW-1:0] kx, ky, kz;
    logic [AW-1:0] s;
    bit keep, ovf, done;
    sx = p.x; sy = p.y; sz = p.z;
    sq = sx*sx + sy*sy + sz*sz;
    mn = m_min; mn = mn*mn;
    mx = m_max; mx = mx*mx;
    keep = !(sq < mn || sq > mx);
    ovf = 1'b0;
    if (keep && m_voxel != 0) begin
      d = m_voxel;
      kx = voxel_key(sx, d); ky = voxel_key(sy, d); kz = voxel_key(sz, d);
      s = home_slot(kx, ky, kz);
      done = 1'b0;
      for (int i = 0; i < PROBES && !done; i++) begin
        if (!seen_occ[s]) begin
          seen_occ[s] = 1'b1;
          seen_kx[s] = kx; seen_ky[s] = ky; seen_kz[s] = kz;
          done = 1'b1;
        end else if (seen_kx[s] == kx && seen_ky[s] == ky && seen_kz[s] == kz) begin
          keep = 1'b0;
          done = 1'b1;
        end
        s = s + 1'b1;
      end
      ovf = !done;
    end
    if (p.last) foreach (seen_occ[i]) seen_occ[i] = 1'b0;
    r = '0;
    if (keep) begin
      r.x = p.x; r.y = p.y; r.z = p.z; r.t = p.t; r.kept = 1'b1; r.ovf = ovf;
    end
    r.scan_end = p.last;
    return keep || p.last;
  endfunction

  // drive one point, wait for acceptance, queue its expected result
  task automatic send_point(input point_t p, input bit known, input bit has_k,
                            input kept_t rk);
    kept_t r;
    bit has;
    if (in_idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) @(negedge clk);
    @(negedge clk);
    pt_in.valid = 1'b1;
    pt_in.point_x = p.x; pt_in.point_y = p.y; pt_in.point_z = p.z;
    pt_in.time_tag = p.t; pt_in.last_in_scan = p.last;
    @(posedge clk);
    while (!pt_in.ready) @(posedge clk);
    has = clip_and_dedup(p, r);
    if (known) begin
      has = has_k;
      r = rk;
    end
    if (has) pending_q.insert(pending_q.size(), r);
    n_items++;
    @(negedge clk);
    pt_in.valid = 1'b0;
  endtask

  // wait for all results, then let a dropped point finish
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [PDW-1:0] val);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = PAW'(idx) << 2; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    case (idx)
      lrcv_pkg::REG_MIN_RANGE:  m_min = val[RW-1:0];
      lrcv_pkg::REG_MAX_RANGE:  m_max = val[RW-1:0];
      lrcv_pkg::REG_VOXEL_SIZE: m_voxel = val[VW-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_check(input logic [1:0] idx, input logic [PDW-1:0] want);
    logic [PDW-1:0] got;
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b0; cfg_penable = 1'b0;
    cfg_paddr = PAW'(idx) << 2;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0;
    if (got !== want) report($sformatf("register %0d read %0h, want %0h", idx, got, want));
  endtask

  task automatic apply_cfg(input int mn, input int mx, input int vs);
    cfg_write(lrcv_pkg::REG_MIN_RANGE, PDW'(mn));
    cfg_write(lrcv_pkg::REG_MAX_RANGE, PDW'(mx));
    cfg_write(lrcv_pkg::REG_VOXEL_SIZE, PDW'(vs));
    cfg_check(lrcv_pkg::REG_MIN_RANGE, {9'd0, m_min});
    cfg_check(lrcv_pkg::REG_MAX_RANGE, {9'd0, m_max});
    cfg_check(lrcv_pkg::REG_VOXEL_SIZE, {16'd0, m_voxel});
  endtask

  // random point: mostly clustered near the origin to hit shared voxels,
  // some full-width noise and some on the range shell
  function automatic point_t rand_point(input int spread);
    point_t p;
    int sel, r;
    sel = int'($urandom_range(0, 99));
    if (sel < 70) begin
      p.x = CW'($signed($urandom_range(0, 2*spread)) - spread);
      p.y = CW'($signed($urandom_range(0, 2*spread)) - spread);
      p.z = CW'($signed($urandom_range(0, 2*spread)) - spread);
    end else if (sel < 85) begin
      p.x = CW'($urandom); p.y = CW'($urandom); p.z = CW'($urandom);
    end else begin
      r = (sel < 92) ? int'(m_min) : int'(m_max);
      r = r + int'($urandom_range(0, 2)) - 1;
      if (r > 8388607) r = 8388607;
      if (r < 0) r = 0;
      p.x = ($urandom_range(0, 1) != 0) ? CW'(-r) : CW'(r);
      p.y = '0; p.z = '0;
    end
    p.t = $urandom;
    if (scan_left == 0) scan_left = int'($urandom_range(1, 60));
    scan_left--;
    p.last = (scan_left == 0);
    return p;
  endfunction

  // result monitor
  always @(posedge clk) begin
    kept_t e;
    if (rst_n && pt_out.valid && pt_out.ready) begin
      n_results++;
      if (pt_out.table_overflow) n_ovf++;
      if (pt_out.scan_end) n_ends++;
      if (pt_out.point_valid) n_kept++;
      if (pending_q.size() == 0) begin
        report("result with no point awaiting one");
      end else begin
        e = pending_q.pop_front();
        if (pt_out.out_x !== e.x) report($sformatf("out_x %0d want %0d", pt_out.out_x, e.x));
        if (pt_out.out_y !== e.y) report($sformatf("out_y %0d want %0d", pt_out.out_y, e.y));
        if (pt_out.out_z !== e.z) report($sformatf("out_z %0d want %0d", pt_out.out_z, e.z));
        if (pt_out.out_time !== e.t)
          report($sformatf("out_time %0h want %0h", pt_out.out_time, e.t));
        if (pt_out.point_valid !== e.kept) report($sformatf("point_valid %b", pt_out.point_valid));
        if (pt_out.table_overflow !== e.ovf)
          report($sformatf("table_overflow %b", pt_out.table_overflow));
        if (pt_out.scan_end !== e.scan_end) report($sformatf("scan_end %b", pt_out.scan_end));
      end
    end
  end

  // receiver stalls in short bursts
  initial begin
    pt_out.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (out_idle_on && $urandom_range(0, 5) == 0) begin
        pt_out.ready = 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        pt_out.ready = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("lidar_range_clip_voxel_downsample_unit_tb failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    kept_t none;
    point_t p;
    int found;
    int phase_cfg[N_PHASE][3] = '{
      '{0, 8388607, 0}, '{0, 8388607, 65535}, '{1000, 50000, 1},
      '{8388607, 0, 100}, '{0, 0, 0}, '{5000, 200000, 100},
      '{0, 100000, 3}, '{200, 30000, 250}};
    int spread[N_PHASE] = '{100000, 4000000, 40000, 5000, 3, 150000, 200, 30000};
    logic [AW-1:0] target;

    pt_in.valid = 1'b0;
    pt_in.point_x = '0; pt_in.point_y = '0; pt_in.point_z = '0;
    pt_in.time_tag = '0; pt_in.last_in_scan = 1'b0;
    none = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values
    cfg_check(lrcv_pkg::REG_MIN_RANGE, 32'd0);
    cfg_check(lrcv_pkg::REG_MAX_RANGE, {9'd0, lrcv_pkg::MAX_RANGE_RST});
    cfg_check(lrcv_pkg::REG_VOXEL_SIZE, 32'd0);

    // directed rows at reset settings: range edges and end-of-scan results
    rw = '0; rw.known = 1; rw.has = 1;
    rw.p = '{x: 0, y: 0, z: 0, t: 32'h0000_0001, last: 0};
    rw.r = '{x: 0, y: 0, z: 0, t: 32'h0000_0001, kept: 1, ovf: 0, scan_end: 0};
    rows.insert(rows.size(), rw);
    rw.p = '{x: 100000, y: 0, z: 0, t: 32'hFFFF_FFFF, last: 0};
    rw.r = '{x: 100000, y: 0, z: 0, t: 32'hFFFF_FFFF, kept: 1, ovf: 0, scan_end: 0};
    rows.insert(rows.size(), rw);
    rw.p = '{x: 0, y: -100000, z: 0, t: 32'h5555_AAAA, last: 0};
    rw.r = '{x: 0, y: -100000, z: 0, t: 32'h5555_AAAA, kept: 1, ovf: 0, scan_end: 0};
    rows.insert(rows.size(), rw);
    rw.has = 0; rw.r = none;
    rw.p = '{x: 100001, y: 0, z: 0, t: 32'h1234_5678, last: 0};
    rows.insert(rows.size(), rw);
    rw.p = '{x: 0, y: 0, z: -100001, t: 32'h1234_5678, last: 0};
    rows.insert(rows.size(), rw);
    rw.has = 1; rw.r = '{x: 0, y: 0, z: 0, t: 0, kept: 0, ovf: 0, scan_end: 1};
    rw.p = '{x: -8388608, y: -8388608, z: -8388608, t: 32'hDEAD_BEEF, last: 1};
    rows.insert(rows.size(), rw);
    rw.p = '{x: 8388607, y: 8388607, z: 8388607, t: 32'hA5A5_5A5A, last: 1};
    rows.insert(rows.size(), rw);
    rw.p = '{x: 0, y: 0, z: -100000, t: 32'h0F0F_F0F0, last: 1};
    rw.r = '{x: 0, y: 0, z: -100000, t: 32'h0F0F_F0F0, kept: 1, ovf: 0, scan_end: 1};
    rows.insert(rows.size(), rw);
    foreach (rows[i]) send_point(rows[i].p, rows[i].known, rows[i].has, rows[i].r);
    rows.delete();
    drain();

    // duplicate voxels, negative floor, and a duplicate that ends the scan
    apply_cfg(0, 100000, 10);
    rw = '0;
    rw.p = '{x: 5, y: 5, z: 5, t: 1, last: 0};     rows.insert(rows.size(), rw);
    rw.p = '{x: 9, y: 0, z: 1, t: 2, last: 0};     rows.insert(rows.size(), rw);
    rw.p = '{x: -1, y: 0, z: 0, t: 3, last: 0};    rows.insert(rows.size(), rw);
    rw.p = '{x: -10, y: 9, z: 9, t: 4, last: 0};   rows.insert(rows.size(), rw);
    rw.p = '{x: -11, y: 0, z: 0, t: 5, last: 0};   rows.insert(rows.size(), rw);
    rw.p = '{x: 0, y: 0, z: 0, t: 6, last: 1};     rows.insert(rows.size(), rw);
    rw.p = '{x: 3, y: 3, z: 3, t: 7, last: 1};     rows.insert(rows.size(), rw);
    foreach (rows[i]) send_point(rows[i].p, 1'b0, 1'b0, none);
    rows.delete();
    drain();

    // fill a whole probe window: nine voxels sharing one home slot
    apply_cfg(0, 100000, 1);
    target = home_slot(24'd1, 24'd0, 24'd0);
    found = 0;
    for (int y = 0; y < 8 && found < PROBES + 1; y++) begin
      for (int x = 1; x < 65536 && found < PROBES + 1; x++) begin
        if (home_slot(CW'(x), CW'(y), '0) == target) begin
          found++;
          p = '{x: CW'(x), y: CW'(y), z: '0, t: $urandom, last: (found == PROBES + 1)};
          send_point(p, 1'b0, 1'b0, none);
        end
      end
    end
    drain();

    // random scans under each register setting; hold off once until empty
    for (int ph = 0; ph < N_PHASE; ph++) begin
      apply_cfg(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2]);
      if (ph == N_PHASE - 2) begin
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
      end
      for (int k = 0; k < PHASE_PTS; k++) begin
        send_point(rand_point(spread[ph]), 1'b0, 1'b0, none);
        if (ph == 2 && k == PHASE_PTS / 2) begin
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
      // close the scan so the next setting starts from an empty table
      p = rand_point(spread[ph]);
      p.last = 1'b1;
      scan_left = 0;
      send_point(p, 1'b0, 1'b0, none);
      drain();
    end

    $display("covered %0d points, %0d results: %0d kept, %0d overflow, %0d scan ends",
             n_items, n_results, n_kept, n_ovf, n_ends);
    $display("settings: reset, full range, voxel 1..65535, min above max, zero range");
    if (errors == 0) begin
      $display("lidar_range_clip_voxel_downsample_unit_tb passed");
    end else begin
      $display("lidar_range_clip_voxel_downsample_unit_tb failed");
    end
    $finish;
  end

endmodule
